// File: rtl/c3br_pkg.sv
// Shared types, widths and register codes for the 3x3 convolution stream core.
package c3br_pkg;

	localparam int MAX_IMAGE_DEF = 64;
	localparam int MIN_SIZE      = 3;
	localparam int SIZE_RESET    = 28;

	localparam int PIX_W     = 9;
	localparam int WT_W      = 16;
	localparam int KROW_W    = 3 * WT_W;
	localparam int SIZE_W    = 7;
	localparam int BIAS_W    = 16;
	localparam int FEAT_W    = 16;
	localparam int IDX_W     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = KROW_W;
	localparam int FRAC_W    = 8;

	// pixel is zero-extended to a signed operand before the multiply
	localparam int PROD_W = PIX_W + 1 + WT_W;
	localparam int RSUM_W = PROD_W + 2;
	localparam int ACC_W  = 32;
	localparam int FEAT_MAX = (1 << FEAT_W) - 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONV_BIAS     = 3'd4;

	typedef logic [PIX_W-1:0] pix_t;
	// window[m][n]: row m (0 = oldest line), column n (2 = newest pixel)
	typedef pix_t [2:0][2:0] window_t;
	typedef logic [KROW_W-1:0] krow_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} meta_t;

endpackage

// File: rtl/c3br_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module c3br_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// same-address read and write in one cycle returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/c3br_front.sv
// Position counters, line-store RAM with write-back forwarding, and the 3x3 window.
module c3br_front #(
	parameter int MAX_IMAGE = c3br_pkg::MAX_IMAGE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [c3br_pkg::SIZE_W-1:0]   image_size,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [c3br_pkg::PIX_W-1:0]    pixel,
	input  logic                          start_of_image,
	input  logic                          s2_free,
	output logic                          fire,
	output c3br_pkg::window_t             win,
	output c3br_pkg::meta_t               meta
);
	import c3br_pkg::*;

	localparam int CW = $clog2(MAX_IMAGE);
	localparam int SW = $clog2(MAX_IMAGE + 1);
	localparam int EW = (SW > SIZE_W) ? SW : SIZE_W;
	localparam int LW = 2 * PIX_W;

	logic [CW-1:0] row_q, col_q;
	logic [CW-1:0] r0, c0, r_nx, c_nx;
	logic [EW-1:0] size_ext, eff_size, c_inc, r_inc;
	logic          prod0, last0, accept;

	logic          v1_q, prod_s1, fwd_s1_q;
	pix_t          px_s1;
	logic [CW-1:0] col_s1;
	meta_t         meta_s1;
	logic [LW-1:0] fwd_data_q, ram_rdata, entry, wb_data;
	pix_t          up, lo;
	logic          s1_go, s1_free;
	window_t       win_q, win_n;

	// clamp the programmed size into the supported range
	always_comb begin
		size_ext = EW'(image_size);
		eff_size = size_ext;
		if (size_ext < EW'(MIN_SIZE)) begin
			eff_size = EW'(MIN_SIZE);
		end else if (size_ext > EW'(MAX_IMAGE)) begin
			eff_size = EW'(MAX_IMAGE);
		end
	end

	always_comb begin
		r0 = start_of_image ? '0 : row_q;
		c0 = start_of_image ? '0 : col_q;
		prod0 = (EW'(r0) >= EW'(2)) && (EW'(c0) >= EW'(2)) &&
			(EW'(r0) < eff_size) && (EW'(c0) < eff_size);
		last0 = (EW'(r0) == eff_size - EW'(1)) && (EW'(c0) == eff_size - EW'(1));
		c_inc = EW'(c0) + EW'(1);
		r_inc = EW'(r0) + EW'(1);
		if (c_inc >= eff_size) begin
			c_nx = '0;
			r_nx = (r_inc >= eff_size) ? '0 : r_inc[CW-1:0];
		end else begin
			c_nx = c_inc[CW-1:0];
			r_nx = r0;
		end
	end

	assign s1_go   = v1_q && (!prod_s1 || s2_free);
	assign s1_free = !v1_q || s1_go;
	assign accept  = in_valid && s1_free;
	assign in_stall = !s1_free;
	assign fire    = s1_go && prod_s1;

	// entry holds {upper, lower}; forward the word written in the accept cycle
	assign entry   = fwd_s1_q ? fwd_data_q : ram_rdata;
	assign up      = entry[LW-1:PIX_W];
	assign lo      = entry[PIX_W-1:0];
	assign wb_data = {lo, px_s1};

	c3br_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_IMAGE)
	) u_line_ram (
		.clk   (clk),
		.we    (s1_go),
		.waddr (col_s1),
		.wdata (wb_data),
		.re    (accept),
		.raddr (c0),
		.rdata (ram_rdata)
	);

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			win_n[m][0] = win_q[m][1];
			win_n[m][1] = win_q[m][2];
		end
		win_n[0][2] = up;
		win_n[1][2] = lo;
		win_n[2][2] = px_s1;
	end

	assign win  = win_n;
	assign meta = meta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			v1_q     <= 1'b0;
			prod_s1  <= 1'b0;
			fwd_s1_q <= 1'b0;
			win_q    <= '0;
		end else begin
			if (accept) begin
				row_q    <= r_nx;
				col_q    <= c_nx;
				prod_s1  <= prod0;
				fwd_s1_q <= s1_go && (col_s1 == c0);
			end
			if (s1_free) begin
				v1_q <= accept;
			end
			if (s1_go) begin
				win_q <= win_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pixel;
			col_s1       <= c0;
			meta_s1.row  <= IDX_W'(r0 - CW'(2));
			meta_s1.col  <= IDX_W'(c0 - CW'(2));
			meta_s1.last <= last0;
			fwd_data_q   <= wb_data;
		end
	end

endmodule

// File: rtl/c3br_mac.sv
// Nine parallel products, row sums, bias, floor shift, ReLU and saturation.
module c3br_mac (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  c3br_pkg::window_t             win,
	input  c3br_pkg::meta_t               meta,
	input  c3br_pkg::krow_t               kernel_row_top,
	input  c3br_pkg::krow_t               kernel_row_mid,
	input  c3br_pkg::krow_t               kernel_row_bottom,
	input  logic signed [c3br_pkg::BIAS_W-1:0] conv_bias,
	output logic                          s2_free,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [c3br_pkg::FEAT_W-1:0]   feature,
	output logic [c3br_pkg::IDX_W-1:0]    out_row,
	output logic [c3br_pkg::IDX_W-1:0]    out_col,
	output logic                          last_of_map
);
	import c3br_pkg::*;

	krow_t                     krow [3];
	logic signed [PROD_W-1:0]  prod_n [3][3];
	logic signed [PROD_W-1:0]  prod_s2 [3][3];
	logic signed [RSUM_W-1:0]  rsum_n [3];
	logic signed [RSUM_W-1:0]  rsum_s3 [3];
	logic signed [ACC_W-1:0]   total, q;
	logic [FEAT_W-1:0]         feat_n;
	logic                      v2_q, v3_q, ov_q;
	logic                      s3_free, out_free;
	meta_t                     meta_s2, meta_s3, meta_q;
	logic [FEAT_W-1:0]         feature_q;

	assign krow[0] = kernel_row_top;
	assign krow[1] = kernel_row_mid;
	assign krow[2] = kernel_row_bottom;

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			for (int n = 0; n < 3; n++) begin
				prod_n[m][n] = PROD_W'($signed({1'b0, win[m][n]}) *
					$signed(krow[m][WT_W*n +: WT_W]));
			end
		end
	end

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			rsum_n[m] = RSUM_W'(prod_s2[m][0]) + RSUM_W'(prod_s2[m][1]) +
				RSUM_W'(prod_s2[m][2]);
		end
	end

	// arithmetic shift gives floor division by 256
	always_comb begin
		total = ACC_W'(rsum_s3[0]) + ACC_W'(rsum_s3[1]) + ACC_W'(rsum_s3[2]) +
			(ACC_W'(conv_bias) <<< FRAC_W);
		q = total >>> FRAC_W;
		if (q < 0) begin
			feat_n = '0;
		end else if (q > ACC_W'(FEAT_MAX)) begin
			feat_n = FEAT_W'(FEAT_MAX);
		end else begin
			feat_n = q[FEAT_W-1:0];
		end
	end

	assign out_free = !ov_q || !out_stall;
	assign s3_free  = !v3_q || out_free;
	assign s2_free  = !v2_q || s3_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (s2_free) begin
				v2_q <= fire;
			end
			if (s3_free) begin
				v3_q <= v2_q;
			end
			if (out_free) begin
				ov_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			prod_s2 <= prod_n;
			meta_s2 <= meta;
		end
		if (v2_q && s3_free) begin
			rsum_s3 <= rsum_n;
			meta_s3 <= meta_s2;
		end
		if (v3_q && out_free) begin
			feature_q <= feat_n;
			meta_q    <= meta_s3;
		end
	end

	assign out_valid   = ov_q;
	assign feature     = feature_q;
	assign out_row     = meta_q.row;
	assign out_col     = meta_q.col;
	assign last_of_map = meta_q.last;

endmodule

// File: rtl/conv3x3_bias_relu_stream_core.sv
// Path: accepted pixel -> stage 1 -> product, row-sum and output registers -> out_valid.
// Throughput: one pixel per cycle unless in_stall is high; the line-store RAM is read at
//   accept, written back as the pixel leaves stage 1, forwarded for a repeated column.
// Results: one feature per pixel whose row and column are both >= 2 and below the size.
// Reset (arst_n low, async): counters, window, valids cleared; size = 28,
//   kernels and bias = 0. The line-store RAM is not cleared.
module conv3x3_bias_relu_stream_core #(
	parameter int MAX_IMAGE = c3br_pkg::MAX_IMAGE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_wr_en,
	input  logic [c3br_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [c3br_pkg::CFG_W-1:0]        cfg_wdata,
	// pixel input words
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [c3br_pkg::PIX_W-1:0]        pixel,
	input  logic                              start_of_image,
	// feature output words
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [c3br_pkg::FEAT_W-1:0]       feature,
	output logic [c3br_pkg::IDX_W-1:0]        out_row,
	output logic [c3br_pkg::IDX_W-1:0]        out_col,
	output logic                              last_of_map
);
	import c3br_pkg::*;

	// configuration registers; to be written only while the core is idle, which the core does not enforce
	logic [SIZE_W-1:0]        image_size_q;
	krow_t                    ktop_q, kmid_q, kbot_q;
	logic signed [BIAS_W-1:0] bias_q;

	// front-end to arithmetic handoff
	logic    s2_free;
	logic    fire;
	window_t win;
	meta_t   meta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= SIZE_W'(SIZE_RESET);
			ktop_q       <= '0;
			kmid_q       <= '0;
			kbot_q       <= '0;
			bias_q       <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_SIZE: begin
					image_size_q <= cfg_wdata[SIZE_W-1:0];
				end
				REG_KERNEL_TOP: begin
					ktop_q <= cfg_wdata[KROW_W-1:0];
				end
				REG_KERNEL_MID: begin
					kmid_q <= cfg_wdata[KROW_W-1:0];
				end
				REG_KERNEL_BOTTOM: begin
					kbot_q <= cfg_wdata[KROW_W-1:0];
				end
				REG_CONV_BIAS: begin
					bias_q <= $signed(cfg_wdata[BIAS_W-1:0]);
				end
				default: ;
			endcase
		end
	end

	// Stage 0/1: raster position, line-store read-modify-write, window shift.
	// Pixels outside a full neighborhood update the store and window and end here.
	c3br_front #(
		.MAX_IMAGE(MAX_IMAGE)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.image_size     (image_size_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel          (pixel),
		.start_of_image (start_of_image),
		.s2_free        (s2_free),
		.fire           (fire),
		.win            (win),
		.meta           (meta)
	);

	// Stage 2/3/out: products, row sums, bias + floor + ReLU + clamp into the
	// output register; out_stall ripples back through the stage valids to in_stall.
	c3br_mac u_mac (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (fire),
		.win               (win),
		.meta              (meta),
		.kernel_row_top    (ktop_q),
		.kernel_row_mid    (kmid_q),
		.kernel_row_bottom (kbot_q),
		.conv_bias         (bias_q),
		.s2_free           (s2_free),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.feature           (feature),
		.out_row           (out_row),
		.out_col           (out_col),
		.last_of_map       (last_of_map)
	);

endmodule

// File: rtl/c3br_checker.sv
// Port-level checks for the convolution stream core, bound to the top level.
module c3br_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [c3br_pkg::FEAT_W-1:0]    feature,
	input logic [c3br_pkg::IDX_W-1:0]     out_row,
	input logic [c3br_pkg::IDX_W-1:0]     out_col,
	input logic                           last_of_map
);

	// a stalled output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_valid && out_stall) |-> out_valid && $stable(feature) &&
			$stable(out_row) && $stable(out_col) && $stable(last_of_map))
		else $error("output word changed while stalled");

	// the last value of a square map sits on its diagonal
	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_map |-> out_row == out_col)
		else $error("last_of_map off the map diagonal");

	// after the last word of a map leaves, an output word right behind it sits at row 0 or column 0
	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_of_map |=> !out_valid || out_row == '0 ||
			out_col == '0)
		else $error("map restart not at column 0");

	// nothing leaves the core on the first edge out of reset
	a_reset_quiet: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind conv3x3_bias_relu_stream_core c3br_checker u_c3br_checker (.*);

// File: tb/sv/c3br_feature_checker.sv
// Scoreboard for the 3x3 convolution stream core: mirrors the datapath and checks feature words.
module c3br_feature_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [c3br_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [c3br_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [c3br_pkg::PIX_W-1:0]     pixel,
	input  logic                           start_of_image,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [c3br_pkg::FEAT_W-1:0]    feature,
	input  logic [c3br_pkg::IDX_W-1:0]     out_row,
	input  logic [c3br_pkg::IDX_W-1:0]     out_col,
	input  logic                           last_of_map,
	output int                             fail_count,
	output int                             pending,
	output int                             checked
);
	import c3br_pkg::*;

	typedef struct packed {
		logic [FEAT_W-1:0] value;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;
	} feature_word_t;

	feature_word_t     expected_features[$];
	pix_t              upper_line [MAX_IMAGE_DEF];
	pix_t              lower_line [MAX_IMAGE_DEF];
	pix_t              win [3][3];
	int                row_pos, col_pos;
	logic [SIZE_W-1:0] size_reg;
	krow_t             kernel [3];
	logic [BIAS_W-1:0] bias_reg;

	function automatic int clamp_size(input logic [SIZE_W-1:0] s);
		if (s < MIN_SIZE)
			return MIN_SIZE;
		if (s > MAX_IMAGE_DEF)
			return MAX_IMAGE_DEF;
		return int'(s);
	endfunction

	task automatic clear_model();
		int i, j;
		for (i = 0; i < MAX_IMAGE_DEF; i++) begin
			upper_line[i] = '0;
			lower_line[i] = '0;
		end
		for (i = 0; i < 3; i++) begin
			for (j = 0; j < 3; j++)
				win[i][j] = '0;
			kernel[i] = '0;
		end
		row_pos = 0;
		col_pos = 0;
		size_reg = SIZE_W'(SIZE_RESET);
		bias_reg = '0;
		expected_features.delete();
		fail_count = 0;
		checked = 0;
	endtask

	// one pixel word: line stores, window shift, and the feature if the window is valid
	task automatic take_pixel(input pix_t px, input logic mark);
		int size, r, c, m, n;
		pix_t up, lo;
		longint acc;
		logic signed [WT_W-1:0] wt;
		logic signed [BIAS_W-1:0] b;
		feature_word_t w;
		size = clamp_size(size_reg);
		if (mark) begin
			row_pos = 0;
			col_pos = 0;
		end
		r = row_pos;
		c = col_pos;
		up = upper_line[c];
		lo = lower_line[c];
		upper_line[c] = lo;
		lower_line[c] = px;
		for (m = 0; m < 3; m++) begin
			win[m][0] = win[m][1];
			win[m][1] = win[m][2];
		end
		win[0][2] = up;
		win[1][2] = lo;
		win[2][2] = px;
		if (r >= 2 && c >= 2 && r < size && c < size) begin
			acc = 0;
			for (m = 0; m < 3; m++) begin
				for (n = 0; n < 3; n++) begin
					wt = kernel[m][n*WT_W +: WT_W];
					acc += longint'(win[m][n]) * longint'(wt);
				end
			end
			b = bias_reg;
			acc += longint'(b) * 256;
			acc = acc >>> FRAC_W;    // floor toward minus infinity
			if (acc < 0)
				w.value = '0;
			else if (acc > FEAT_MAX)
				w.value = FEAT_W'(FEAT_MAX);
			else
				w.value = acc[FEAT_W-1:0];
			w.row = IDX_W'(r - 2);
			w.col = IDX_W'(c - 2);
			w.last = (r == size - 1) && (c == size - 1);
			expected_features.insert(expected_features.size(), w);
		end
		c++;
		if (c >= size) begin
			c = 0;
			r++;
			if (r >= size)
				r = 0;
		end
		row_pos = r;
		col_pos = c;
	endtask

	task automatic check_feature();
		feature_word_t w;
		checked++;
		if (expected_features.size() == 0) begin
			$display("%0t: feature word with none expected: value=%0d row=%0d col=%0d last=%0b",
				$time, feature, out_row, out_col, last_of_map);
			fail_count++;
			return;
		end
		w = expected_features.pop_front();
		if (feature !== w.value) begin
			$display("%0t: feature at (%0d,%0d): expected %0d, got %0d",
				$time, w.row, w.col, w.value, feature);
			fail_count++;
		end
		if (out_row !== w.row) begin
			$display("%0t: out_row: expected %0d, got %0d", $time, w.row, out_row);
			fail_count++;
		end
		if (out_col !== w.col) begin
			$display("%0t: out_col: expected %0d, got %0d", $time, w.col, out_col);
			fail_count++;
		end
		if (last_of_map !== w.last) begin
			$display("%0t: last_of_map at (%0d,%0d): expected %0b, got %0b",
				$time, w.row, w.col, w.last, last_of_map);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			pending = 0;
		end else begin
			// drain side first: a word leaving now belongs to an older pixel
			if (out_valid && !out_stall)
				check_feature();
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_IMAGE_SIZE:    size_reg = cfg_wdata[SIZE_W-1:0];
					REG_KERNEL_TOP:    kernel[0] = cfg_wdata[KROW_W-1:0];
					REG_KERNEL_MID:    kernel[1] = cfg_wdata[KROW_W-1:0];
					REG_KERNEL_BOTTOM: kernel[2] = cfg_wdata[KROW_W-1:0];
					REG_CONV_BIAS:     bias_reg = cfg_wdata[BIAS_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				take_pixel(pixel, start_of_image);
			pending = expected_features.size();
		end
	end

endmodule

// File: tb/sv/tb_conv3x3_bias_relu_stream_core.sv
// Testbench top for the 3x3 convolution stream core: stimulus, back-pressure and verdict.
module tb_conv3x3_bias_relu_stream_core;
	import c3br_pkg::*;

	localparam int PIXEL_TARGET  = 1450;
	// pixels with no feature may still be in the pipeline after the last feature is back
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 160;
	localparam int DRAIN_LIMIT   = 5000;
	// Worst correct run is ~1500 words plus holds and config gaps; the limit is set
	// about ten times above it (8 time units per cycle).
	localparam int RUN_LIMIT     = 3_200_000;

	// receiver stall patterns
	typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;
	logic                 in_valid;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel;
	logic                 start_of_image;
	logic                 out_valid;
	logic                 out_stall;
	logic [FEAT_W-1:0]    feature;
	logic [IDX_W-1:0]     out_row;
	logic [IDX_W-1:0]     out_col;
	logic                 last_of_map;

	int fail_count, pending, checked;
	int words_sent    = 0;
	int settings_used = 0;
	int burst_left    = 0;
	int holds_asked   = 0;
	int holds_done    = 0;
	bit calm          = 1'b0;    // sender offers back to back when set

	conv3x3_bias_relu_stream_core dut (.*);

	c3br_feature_checker feature_chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("%0t: run limit hit, %0d features still expected", $time, pending);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [WT_W-1:0] pick_weight();
		int v;
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return WT_W'($urandom);
			default: begin
				// small weights keep most sums inside the Q8.8 range
				v = int'($urandom_range(0, 1200)) - 600;
				return v[WT_W-1:0];
			end
		endcase
	endfunction

	function automatic krow_t pick_row();
		return {pick_weight(), pick_weight(), pick_weight()};
	endfunction

	function automatic logic [BIAS_W-1:0] pick_bias();
		int v;
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return BIAS_W'($urandom);
			default: begin
				v = int'($urandom_range(0, 6000)) - 3000;
				return v[BIAS_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return PIX_W'($urandom_range(257, 511));    // above 1.0, raw 9-bit value
			1: return $urandom_range(0, 1) ? PIX_W'(256) : PIX_W'(0);
			default: return PIX_W'($urandom_range(0, 256));
		endcase
	endfunction

	function automatic int clamp_size(input logic [SIZE_W-1:0] s);
		if (s < MIN_SIZE)
			return MIN_SIZE;
		if (s > MAX_IMAGE_DEF)
			return MAX_IMAGE_DEF;
		return int'(s);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = value;
		@(posedge clk);
	endtask

	// all five registers; unused upper bits of size and bias carry junk
	task automatic configure(input logic [SIZE_W-1:0] sz, input krow_t top_row,
			input krow_t mid_row, input krow_t bottom_row, input logic [BIAS_W-1:0] bias);
		logic [CFG_W-1:0] word;
		word = CFG_W'({$urandom, $urandom});
		word[SIZE_W-1:0] = sz;
		write_reg(REG_IMAGE_SIZE, word);
		write_reg(REG_KERNEL_TOP, top_row);
		write_reg(REG_KERNEL_MID, mid_row);
		write_reg(REG_KERNEL_BOTTOM, bottom_row);
		word = CFG_W'({$urandom, $urandom});
		word[BIAS_W-1:0] = bias;
		write_reg(REG_CONV_BIAS, word);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		settings_used++;
	endtask

	// One pixel word. Bursts of random length, random gaps between them unless calm.
	task automatic send_word(input logic [PIX_W-1:0] value, input logic mark);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = calm ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		pixel = value;
		start_of_image = mark;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// Idle point for register writes: every feature back, then let the pipe empty.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Receiver: own stall pattern, each held for a random run before a new one is picked. A requested
	// hold-off keeps stall high for HOLD_CYCLES so the core backs up into its input.
	initial begin : receiver
		stall_mode_e mode;
		int left, tick;
		mode = STALL_NONE;
		left = 0;
		tick = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (holds_done != holds_asked) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holds_done++;
			end else begin
				if (left == 0) begin
					mode = stall_mode_e'($urandom_range(0, 3));
					left = $urandom_range(8, 80);
				end
				left--;
				case (mode)
					STALL_NONE:     out_stall = 1'b0;
					STALL_SPARSE:   out_stall = ($urandom_range(0, 9) < 3);
					STALL_PERIODIC: out_stall = (tick % 5 >= 3);
					default:        out_stall = ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	initial begin : stimulus
		int i, eff, prev_eff, n_items, pos, phase_idx, waited, sz_pick;
		logic [SIZE_W-1:0] sz;
		logic mark;
		bit grow;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pixel = '0;
		start_of_image = 1'b0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed part ---
		// Size code 0 acts as 3. All-max weights and bias with all-ones pixels
		// (above 1.0) drive the sum far past the saturation point.
		configure(SIZE_W'(0), {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, 16'h7FFF);
		for (i = 0; i < 9; i++)
			send_word({PIX_W{1'b1}}, i == 0);
		// next image follows on the position wrap, no start mark; 1.0 and 0 alternate
		for (i = 0; i < 9; i++)
			send_word(i[0] ? PIX_W'(0) : PIX_W'(256), 1'b0);
		settle();
		// Size code 2 also acts as 3. Most negative weights and bias: ReLU gives 0.
		configure(SIZE_W'(2), {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, 16'h8000);
		for (i = 0; i < 9; i++)
			send_word(i[1] ? PIX_W'(0) : PIX_W'(256), i == 0);
		prev_eff = 3;
		phase_idx = 0;

		// --- random part: one register setting per phase ---
		while (words_sent < PIXEL_TARGET) begin
			settle();
			phase_idx++;
			sz_pick = $urandom_range(0, 15);
			if (phase_idx == 2)
				sz = SIZE_W'(5);
			else if (sz_pick == 0)
				sz = SIZE_W'($urandom_range(0, 2));      // below range, acts as 3
			else if (sz_pick == 1)
				sz = SIZE_W'($urandom_range(65, 127));   // above range, acts as 64
			else if (sz_pick <= 3)
				sz = SIZE_W'($urandom_range(20, 64));
			else
				sz = SIZE_W'($urandom_range(3, 10));
			eff = clamp_size(sz);
			configure(sz, pick_row(), pick_row(), pick_row(), pick_bias());

			// Growing the size leaves line-store columns past the old width stale
			// for the row in progress, so restart at 0,0. Shrinking mid-image is
			// allowed: out-of-size positions give nothing and wrap.
			grow = eff > prev_eff;
			prev_eff = eff;

			// big images: only the first few rows, then cut off mid-image
			if (eff > 16)
				n_items = eff * $urandom_range(3, 5);
			else if (phase_idx == 2)
				n_items = 8 * eff * eff;
			else
				n_items = eff * eff * $urandom_range(1, 3)
					+ (($urandom_range(0, 2) == 0) ? $urandom_range(1, eff * eff - 1) : 0);
			// keep the total near the target
			if (n_items > PIXEL_TARGET - words_sent)
				n_items = PIXEL_TARGET - words_sent;

			calm = ($urandom_range(0, 3) == 0) || (phase_idx == 2);
			// long receiver hold-off while the sender keeps pushing
			if (phase_idx == 2)
				holds_asked++;

			for (i = 0; i < n_items; i++) begin
				pos = i % (eff * eff);
				if (i == 0)
					mark = grow || ($urandom_range(0, 1) == 1);
				else if (pos == 0)
					mark = ($urandom_range(0, 4) != 0);   // sometimes rely on the wrap
				else
					mark = ($urandom_range(0, 80) == 0);  // broken image: restart mid-way
				// halfway through one phase, sender waits for every feature to come back
				if (phase_idx == 3 && i == n_items / 2) begin
					@(negedge clk);
					in_valid = 1'b0;
					while (pending != 0) @(negedge clk);
				end
				send_word(pick_pixel(), mark);
			end
		end

		// --- end of run ---
		@(negedge clk);
		in_valid = 1'b0;
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (pending != 0)
			$display("%0t: %0d expected feature words never arrived", $time, pending);
		$display("Sent %0d pixel words under %0d register settings; %0d feature words checked.",
			words_sent, settings_used, checked);
		$display("Included out-of-range sizes, a %0d-cycle output hold-off and a full drain.",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
